// ===== src/plst_pkg.sv =====
// Package for the positional list engine: request and result beat types,
// request and status codes, and default sizes. No dependencies.
`default_nettype none

package plst_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W    = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } t_out_item;

    // Completion report from the sequencer to the result register.
    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic                rd_ok;
    } t_fin;

endpackage

`default_nettype wire

// ===== src/plst_mem.sv =====
// Entry store of the positional list engine: one write port and one read
// port, read data registered. Depends on nothing.
`default_nettype none

module plst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/plst_seq.sv =====
// Sequencer of the positional list engine: range checks, entry count and the
// read-then-write shift loop over the entry store. Depends on plst_pkg.
`default_nettype none

module plst_seq #(
    parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire plst_pkg::t_in_item                  i_item,
    output logic                                     o_busy,
    output logic                                     o_we,
    output logic [$clog2(CAPACITY)-1:0]              o_waddr,
    output logic [DATA_WIDTH-1:0]                    o_wdata,
    output logic                                     o_re,
    output logic [$clog2(CAPACITY)-1:0]              o_raddr,
    input  wire logic [DATA_WIDTH-1:0]               i_rdata,
    output logic [$clog2(CAPACITY+1)-1:0]            o_count,
    output plst_pkg::t_fin                           o_fin
);
    import plst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MRD  = 5'b00010,
        S_MWR  = 5'b00100,
        S_FILL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [REQ_W-1:0]      r_op, n_op;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_cursor, n_cursor;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_rd_ok, n_rd_ok;

    logic [XW-1:0]          pos_x, cnt_x, cnt_m1_x;
    logic [CW-1:0]          cnt_m1;
    logic [127:0]           value_ext;
    logic [DATA_WIDTH-1:0]  in_word;

    assign pos_x     = XW'(i_item.position);
    assign cnt_x     = XW'(r_count);
    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m1_x  = XW'(cnt_m1);
    assign value_ext = {{(128 - VALUE_W){1'b0}}, i_item.value};
    assign in_word   = value_ext[DATA_WIDTH-1:0];

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_op     = r_op;
        n_pos    = r_pos;
        n_cursor = r_cursor;
        n_value  = r_value;
        n_status = r_status;
        n_rd_ok  = r_rd_ok;
        o_we     = 1'b0;
        o_waddr  = r_pos;
        o_wdata  = r_value;
        o_re     = 1'b0;
        o_raddr  = r_cursor;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op     = i_item.req_type;
                    n_value  = in_word;
                    n_pos    = pos_x[AW-1:0];
                    n_status = ST_DONE;
                    n_rd_ok  = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_item.req_type)
                        REQ_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (r_count == CAP_C) begin
                                n_status = ST_FULL;
                            end else if (cnt_x > pos_x) begin
                                // Shift from the back toward the position.
                                n_cursor = cnt_m1[AW-1:0];
                                n_state  = S_MRD;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = pos_x[AW-1:0];
                                o_wdata = in_word;
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else if (cnt_m1_x > pos_x) begin
                                n_cursor = pos_x[AW-1:0] + AW'(1);
                                n_state  = S_MRD;
                            end else begin
                                n_count = cnt_m1;
                            end
                        end
                        REQ_READ: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = pos_x[AW-1:0];
                                n_rd_ok = 1'b1;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end
            S_MRD: begin
                o_re    = 1'b1;
                o_raddr = r_cursor;
                n_state = S_MWR;
            end
            S_MWR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                if (r_op == REQ_INSERT) begin
                    o_waddr = r_cursor + AW'(1);
                    if (r_cursor == r_pos) begin
                        n_state = S_FILL;
                    end else begin
                        n_cursor = r_cursor - AW'(1);
                        n_state  = S_MRD;
                    end
                end else begin
                    o_waddr = r_cursor - AW'(1);
                    if (r_cursor == cnt_m1[AW-1:0]) begin
                        n_count = cnt_m1;
                        n_state = S_DONE;
                    end else begin
                        n_cursor = r_cursor + AW'(1);
                        n_state  = S_MRD;
                    end
                end
            end
            S_FILL: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_value;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_pos    <= n_pos;
        r_cursor <= n_cursor;
        r_value  <= n_value;
        r_status <= n_status;
        r_rd_ok  <= n_rd_ok;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_count     = r_count;
    assign o_fin.valid  = (r_state == S_DONE);
    assign o_fin.status = r_status;
    assign o_fin.rd_ok  = r_rd_ok;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_we && o_re))
        else $error("store read and written in the same cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_state == S_IDLE)
        else $error("completion not followed by idle");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> $stable(r_count))
        else $error("entry count moved while idle");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> (r_count == $past(r_count) + CW'(1)
            || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire

// ===== src/positional_list_engine_unit.sv =====
// Top level of the positional list engine: entry store, sequencer and the
// result register. Depends on plst_pkg, plst_mem and plst_seq.
`default_nettype none

// Ordered list of up to CAPACITY words. A request beat is taken when start is
// high and busy is low; busy then stays high until the request is finished.
// Read requests, out-of-range requests, a full-list insert, an insert at the
// end and a remove of the last entry need no shift loop. An insert at a
// position p below the count moves each entry from the back down to p one
// place up and then writes the new word at p; a remove at p moves each entry
// above p one place down. Each shifted entry is read from the store and then
// written back. The result beat appears on o_result with o_valid high for
// exactly one cycle, the first cycle in which busy is low again, and must be
// taken then: there is no way to hold it off. Results come in request order,
// one per request. The store needs no clearing after reset.
module positional_list_engine_unit #(
    parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire plst_pkg::t_in_item i_item,
    output logic                    o_valid,
    output plst_pkg::t_out_item     o_result
);
    import plst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata, rdata;
    logic [CW-1:0]         count;
    t_fin                  fin;
    logic [127:0]          rd_ext;
    logic [31:0]           cnt_ext;

    plst_mem #(
        .DEPTH(CAPACITY),
        .WIDTH(DATA_WIDTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    plst_seq #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_item (i_item),
        .o_busy (busy),
        .o_we   (we),
        .o_waddr(waddr),
        .o_wdata(wdata),
        .o_re   (re),
        .o_raddr(raddr),
        .i_rdata(rdata),
        .o_count(count),
        .o_fin  (fin)
    );

    assign rd_ext  = {{(128 - DATA_WIDTH){1'b0}}, rdata};
    assign cnt_ext = {{(32 - CW){1'b0}}, count};

    logic r_valid;
    t_out_item r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= fin.valid;
        end
    end

    // The store's read data still holds the word fetched for a read request.
    always_ff @(posedge i_clk) begin
        if (fin.valid) begin
            r_result.status     <= fin.status;
            r_result.read_value <= fin.rd_ok ? rd_ext[VALUE_W-1:0] : '0;
            r_result.count      <= cnt_ext[COUNT_W-1:0];
            r_result.is_empty   <= (count == '0);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
